/* hdl/ttuc_pkg.sv */
// shared widths, mode codes and the record carried through the converter pipeline
package ttuc_pkg;

  localparam int AMT_W  = 64;
  localparam int FAC_W  = 32;
  localparam int DIV1_N = AMT_W;   // quotient bits of the whole-second division
  localparam int DIV2_N = FAC_W;   // quotient bits of the remainder division

  localparam logic [FAC_W-1:0] FREQ_RESET = 32'd1000000;

  localparam logic [1:0] MODE_T2U_FLOOR = 2'd0;
  localparam logic [1:0] MODE_T2U_CEIL  = 2'd1;
  localparam logic [1:0] MODE_U2T_CEIL  = 2'd2;
  localparam logic [1:0] MODE_UNUSED    = 2'd3;

  // per-request side data that travels alongside the division state
  typedef struct packed {
    logic             ceil_it;
    logic             special;     // result fixed regardless of arithmetic
    logic             special_ovf; // fixed result is all ones with overflow
    logic [FAC_W-1:0] mul;
    logic [FAC_W-1:0] div;
    logic [AMT_W-1:0] base;
    logic             base_ovf;
  } side_t;

  // state of one restoring division step
  typedef struct packed {
    logic [FAC_W-1:0] rem;
    logic [AMT_W-1:0] work;        // dividend bits on top, quotient bits enter at the bottom
    side_t            side;
  } cell_t;

endpackage

/* hdl/ttuc_div_cell.sv */
// one restoring division step: shift in a dividend bit, trial subtract, record a quotient bit
module ttuc_div_cell import ttuc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  vld_i,
  input  cell_t cell_i,
  output logic  vld_o,
  output cell_t cell_o
);

  logic             vld_r;
  cell_t            cell_r;
  cell_t            cell_nxt;
  logic [FAC_W:0]   trial;
  logic [FAC_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {cell_i.rem, cell_i.work[AMT_W-1]};
    diff  = trial - {1'b0, cell_i.side.div};
    ge    = trial >= {1'b0, cell_i.side.div};
    cell_nxt      = cell_i;
    // remainder stays below the divisor, so the low bits hold it exactly
    cell_nxt.rem  = ge ? diff[FAC_W-1:0] : trial[FAC_W-1:0];
    cell_nxt.work = {cell_i.work[AMT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign cell_o = cell_r;

endmodule

/* hdl/ttuc_mul_unit.sv */
// whole-second product and remainder product, one 32x32 multiply per stage
module ttuc_mul_unit import ttuc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  vld_i,
  input  cell_t cell_i,   // quotient in work, remainder in rem
  output logic  vld_o,
  output cell_t cell_o    // loaded for the remainder division
);

  logic [2:0]         vld_r;
  logic [AMT_W-1:0]   lo1_r, lo2_r;
  logic [FAC_W-1:0]   whi1_r;
  logic [AMT_W-1:0]   hi2_r;
  logic [FAC_W-1:0]   part1_r, part2_r;
  side_t              side1_r, side2_r;
  cell_t              cell_r;
  cell_t              cell_nxt;
  logic [AMT_W:0]     base_sum;
  logic [AMT_W-1:0]   prod;

  always_comb begin
    base_sum = {1'b0, lo2_r} + {1'b0, hi2_r[FAC_W-1:0], {FAC_W{1'b0}}};
    prod     = AMT_W'(part2_r) * AMT_W'(side2_r.mul);
    cell_nxt               = '0;
    cell_nxt.side          = side2_r;
    cell_nxt.side.base     = base_sum[AMT_W-1:0];
    cell_nxt.side.base_ovf = (hi2_r[AMT_W-1:FAC_W] != '0) || base_sum[AMT_W];
    // prod is below div * 2^32, so its upper half already sits below the divisor
    cell_nxt.rem           = prod[AMT_W-1:FAC_W];
    cell_nxt.work          = {prod[FAC_W-1:0], {(AMT_W-FAC_W){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo1_r   <= AMT_W'(cell_i.work[FAC_W-1:0]) * AMT_W'(cell_i.side.mul);
      whi1_r  <= cell_i.work[AMT_W-1:FAC_W];
      part1_r <= cell_i.rem;
      side1_r <= cell_i.side;

      hi2_r   <= AMT_W'(whi1_r) * AMT_W'(side1_r.mul);
      lo2_r   <= lo1_r;
      part2_r <= part1_r;
      side2_r <= side1_r;

      cell_r  <= cell_nxt;
    end
  end

  assign vld_o  = vld_r[2];
  assign cell_o = cell_r;

endmodule

/* hdl/tick_time_unit_converter.sv */
// tick / time-unit converter: two chains of division cells around a multiply unit
//
//   port group   direction  handshake        payload
//   in_*         request in  in_valid/in_stall  in_mode, in_amount, in_units_per_second
//   out_*        result out  out_valid/out_stall out_converted, out_overflow
//   cfg_*        write only  cfg_wr_en          cfg_wr_data (tick_frequency)
//
// one request per cycle while in_stall is low; each result passes through 64 cells of the
// whole-second division, 3 multiply stages, 32 cells of the remainder division and the
// output register. rst_n is synchronous and clears all valid flags and sets the
// frequency to 1000000. a skid register behind the output absorbs one result; in_stall
// rises only once both are occupied.
module tick_time_unit_converter import ttuc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_mode,
  input  logic [AMT_W-1:0] in_amount,
  input  logic [FAC_W-1:0] in_units_per_second,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [AMT_W-1:0] out_converted,
  output logic             out_overflow,
  input  logic             cfg_wr_en,
  input  logic [FAC_W-1:0] cfg_wr_data
);

  logic [FAC_W-1:0] freq_r;

  logic   v1 [0:DIV1_N];
  cell_t  c1 [0:DIV1_N];
  logic   v2 [0:DIV2_N];
  cell_t  c2 [0:DIV2_N];

  logic   en;
  logic   taken;

  logic             out_valid_r, skid_valid_r;
  logic [AMT_W-1:0] out_conv_r, skid_conv_r;
  logic             out_ovf_r, skid_ovf_r;
  logic [AMT_W-1:0] fin_conv;
  logic             fin_ovf;
  logic [FAC_W:0]   frac;
  logic [AMT_W:0]   sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= FREQ_RESET;
    end else if (cfg_wr_en) begin
      freq_r <= cfg_wr_data;
    end
  end

  // pipeline moves whenever the skid register is free
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign taken    = out_valid_r && !out_stall;

  always_comb begin
    c1[0]      = '0;
    c1[0].work = in_amount;
    v1[0]      = in_valid;
    unique case (in_mode)
      MODE_T2U_FLOOR, MODE_T2U_CEIL: begin
        c1[0].side.mul         = in_units_per_second;
        c1[0].side.div         = freq_r;
        c1[0].side.ceil_it     = (in_mode == MODE_T2U_CEIL);
        c1[0].side.special     = (freq_r == '0);
        c1[0].side.special_ovf = (freq_r == '0);
      end
      MODE_U2T_CEIL: begin
        c1[0].side.mul         = freq_r;
        c1[0].side.div         = in_units_per_second;
        c1[0].side.ceil_it     = 1'b1;
        c1[0].side.special     = (in_units_per_second == '0);
        c1[0].side.special_ovf = (in_units_per_second == '0);
      end
      MODE_UNUSED: begin
        // unused mode gives zero without overflow
        c1[0].side.div         = '1;
        c1[0].side.special     = 1'b1;
        c1[0].side.special_ovf = 1'b0;
      end
      default: begin
        c1[0].side.special     = 1'b1;
      end
    endcase
  end

  for (genvar i = 0; i < DIV1_N; i++) begin : g_div1
    ttuc_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (v1[i]),
      .cell_i (c1[i]),
      .vld_o  (v1[i+1]),
      .cell_o (c1[i+1])
    );
  end

  ttuc_mul_unit u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v1[DIV1_N]),
    .cell_i (c1[DIV1_N]),
    .vld_o  (v2[0]),
    .cell_o (c2[0])
  );

  for (genvar i = 0; i < DIV2_N; i++) begin : g_div2
    ttuc_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (v2[i]),
      .cell_i (c2[i]),
      .vld_o  (v2[i+1]),
      .cell_o (c2[i+1])
    );
  end

  // fraction quotient sits in the low half of work after the remainder division
  always_comb begin
    frac = {1'b0, c2[DIV2_N].work[FAC_W-1:0]}
         + (FAC_W+1)'(c2[DIV2_N].side.ceil_it && (c2[DIV2_N].rem != '0));
    sum  = {1'b0, c2[DIV2_N].side.base} + (AMT_W+1)'(frac);
    if (c2[DIV2_N].side.special) begin
      fin_conv = {AMT_W{c2[DIV2_N].side.special_ovf}};
      fin_ovf  = c2[DIV2_N].side.special_ovf;
    end else begin
      fin_conv = sum[AMT_W-1:0];
      fin_ovf  = c2[DIV2_N].side.base_ovf || sum[AMT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (taken || !out_valid_r) begin
        out_valid_r <= skid_valid_r || (en && v2[DIV2_N]);
      end
      if (skid_valid_r) begin
        skid_valid_r <= !taken;
      end else begin
        skid_valid_r <= en && v2[DIV2_N] && out_valid_r && !taken;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (taken || !out_valid_r) begin
      if (skid_valid_r) begin
        out_conv_r <= skid_conv_r;
        out_ovf_r  <= skid_ovf_r;
      end else begin
        out_conv_r <= fin_conv;
        out_ovf_r  <= fin_ovf;
      end
    end
    if (!skid_valid_r) begin
      skid_conv_r <= fin_conv;
      skid_ovf_r  <= fin_ovf;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_converted = out_conv_r;
  assign out_overflow  = out_ovf_r;

endmodule

/* hdl/ttuc_checker.sv */
// port-level checks for the converter, bound to the top level
module ttuc_checker import ttuc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [AMT_W-1:0] out_converted,
  input logic             out_overflow
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_converted) && $stable(out_overflow))
    else $error("stalled result changed");

  // requests are held back only when both output slots are full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("request stalled with output empty");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("request stalled without a stalled result before");

endmodule

bind tick_time_unit_converter ttuc_checker u_ttuc_checker (.*);
